// ===== hw/rtl/rntd_pkg.sv =====
// Shared types, constants and helpers for the radix number-to-digits block.
// No dependencies; every other file imports this package.
package rntd_pkg;

  // Default geometry of the input value and the fraction digit budget
  localparam int unsigned INT_BITS_DEF    = 32;
  localparam int unsigned FRAC_BITS_DEF   = 52;
  localparam int unsigned FRAC_BUDGET_DEF = 48;

  // Field widths
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CHAR_W  = 7;

  // Radix register reset value and legal range
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO       = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 7'h57;  // 'a' minus ten
  localparam logic [CHAR_W-1:0] CHAR_POINT      = 7'h2e;  // '.'
  localparam logic [DIGIT_W-1:0] DIGIT_TOP      = 6'd35;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN      = 6'd10;

  // One character on its way to the pair packer
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } rntd_char_t;

  // Map a digit value onto 0-9 then a-z, clamping at 'z'
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] dc;
    dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
    if (dc < DIGIT_TEN) begin
      return CHAR_ZERO + {1'b0, dc};
    end else begin
      return CHAR_ALPHA_BASE + {1'b0, dc};
    end
  endfunction

endpackage

// ===== hw/rtl/rntd_in_if.sv =====
// Input channel of the radix number-to-digits block: one number per request.
// Depends on rntd_pkg for default widths.
interface rntd_in_if import rntd_pkg::*; #(
  parameter int unsigned INT_BITS  = INT_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [INT_BITS-1:0]  integer_part;
  logic [FRAC_BITS-1:0] fraction_part;

  modport source (output valid, output integer_part, output fraction_part, input ready);
  modport sink   (input valid, input integer_part, input fraction_part, output ready);
endinterface

// ===== hw/rtl/rntd_out_if.sv =====
// Output channel of the radix number-to-digits block: up to two characters per request.
// Depends on rntd_pkg for the character width.
interface rntd_out_if import rntd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] first_char;
  logic [CHAR_W-1:0] second_char;
  logic              second_valid;
  logic              last;

  modport source (output valid, output first_char, output second_char,
                  output second_valid, output last, input ready);
  modport sink   (input valid, input first_char, input second_char,
                  input second_valid, input last, output ready);
endinterface

// ===== hw/rtl/rntd_div_unit.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, small divisor.
// Depends on rntd_pkg for the radix width.
module rntd_div_unit import rntd_pkg::*; #(
  parameter int unsigned INT_BITS = INT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [INT_BITS-1:0] dividend_i,
  input  logic [RADIX_W-1:0]  divisor_i,
  output logic                done_o,
  output logic [INT_BITS-1:0] quotient_o,
  output logic [DIGIT_W-1:0]  remainder_o
);

  localparam int unsigned CNT_W = $clog2(INT_BITS + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [INT_BITS-1:0] quo_q, quo_d;
  logic [DIGIT_W-1:0]  rem_q, rem_d;
  logic [DIGIT_W:0]    shifted;
  logic                fits;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    shifted = {rem_q, quo_q[INT_BITS-1]};
    fits    = shifted >= {1'b0, divisor_i};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(INT_BITS);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? DIGIT_W'(shifted - {1'b0, divisor_i}) : DIGIT_W'(shifted);
      quo_d = {quo_q[INT_BITS-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== hw/rtl/rntd_pair_packer.sv =====
// Packs the character stream into two-character output requests.
// Depends on rntd_pkg and the rntd_out_if channel.
module rntd_pair_packer import rntd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       chr_valid_i,
  input  rntd_char_t chr_i,
  output logic       chr_ready_o,
  rntd_out_if.source out_o
);

  logic              out_valid_q, out_valid_d;
  logic              hold_valid_q, hold_valid_d;
  logic [CHAR_W-1:0] hold_q;
  logic [CHAR_W-1:0] first_q, second_q;
  logic              second_valid_q, last_q;
  logic              out_free;
  logic              chr_fire;
  logic              load_out;

  assign out_free    = !out_valid_q || out_o.ready;
  assign chr_ready_o = out_free || (!hold_valid_q && !chr_i.last);
  assign chr_fire    = chr_valid_i && chr_ready_o;
  assign load_out    = chr_fire && (hold_valid_q || chr_i.last);

  // Pair a held character with the next one, or flush a lone last one
  always_comb begin
    out_valid_d  = out_valid_q && !out_o.ready;
    hold_valid_d = hold_valid_q;
    if (load_out) begin
      out_valid_d  = 1'b1;
      hold_valid_d = 1'b0;
    end else if (chr_fire) begin
      hold_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  // Load the payload registers
  always_ff @(posedge clk_i) begin
    if (chr_fire && !load_out) begin
      hold_q <= chr_i.code;
    end
    if (load_out) begin
      if (hold_valid_q) begin
        first_q        <= hold_q;
        second_q       <= chr_i.code;
        second_valid_q <= 1'b1;
      end else begin
        first_q        <= chr_i.code;
        second_q       <= '0;
        second_valid_q <= 1'b0;
      end
      last_q <= chr_i.last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.first_char   = first_q;
  assign out_o.second_char  = second_q;
  assign out_o.second_valid = second_valid_q;
  assign out_o.last         = last_q;

  // A request with one character only ever closes the string
  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !second_valid_q) |-> last_q)
    else $error("single-character request without last");

  // Nothing stays held after the closing character
  a_no_hold_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chr_fire && chr_i.last) |=> !hold_valid_q)
    else $error("character held after end of string");

endmodule

// ===== hw/rtl/radix_number_to_digits.sv =====
// Radix number-to-digits converter, top level.
// Each integer digit comes from the bit-serial divider and is read back from the digit
//   buffer (S_INT_RD, then S_INT_EMIT); the point and each fraction digit are emitted
//   straight from the sequencer, which stalls while the pair packer is not ready.
// Throughput: one number at a time; the next is taken once the last character is packed.
// Reset: radix returns to 10, the sequencer idles, no output request is pending.
module radix_number_to_digits import rntd_pkg::*; #(
  parameter int unsigned INT_BITS          = INT_BITS_DEF,
  parameter int unsigned FRAC_BITS         = FRAC_BITS_DEF,
  parameter int unsigned FRAC_DIGIT_BUDGET = FRAC_BUDGET_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RADIX_W-1:0] cfg_wdata_i,
  rntd_in_if.sink            in_i,
  rntd_out_if.source         out_o
);

  localparam int unsigned IDX_W  = $clog2(INT_BITS);
  localparam int unsigned NDIG_W = $clog2(INT_BITS + 1);
  localparam int unsigned CNT_W  = $clog2(FRAC_DIGIT_BUDGET + 1);
  localparam int unsigned PROD_W = FRAC_BITS + RADIX_W;
  localparam logic [CNT_W-1:0] LIM_1 = CNT_W'(FRAC_DIGIT_BUDGET / 1);
  localparam logic [CNT_W-1:0] LIM_2 = CNT_W'(FRAC_DIGIT_BUDGET / 2);
  localparam logic [CNT_W-1:0] LIM_3 = CNT_W'(FRAC_DIGIT_BUDGET / 3);
  localparam logic [CNT_W-1:0] LIM_4 = CNT_W'(FRAC_DIGIT_BUDGET / 4);
  localparam logic [CNT_W-1:0] LIM_5 = CNT_W'(FRAC_DIGIT_BUDGET / 5);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DIV      = 6'b000010,
    S_INT_RD   = 6'b000100,
    S_INT_EMIT = 6'b001000,
    S_POINT    = 6'b010000,
    S_FRAC     = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [RADIX_W-1:0]   radix_q;
  logic [RADIX_W-1:0]   r_eff;
  logic [RADIX_W-1:0]   r_q, r_d;
  logic [CNT_W-1:0]     limit_eff;
  logic [CNT_W-1:0]     limit_q, limit_d;
  logic [CNT_W-1:0]     frac_cnt_q, frac_cnt_d;
  logic [FRAC_BITS-1:0] frac_q, frac_d;
  logic                 frac_nz_q, frac_nz_d;
  logic [NDIG_W-1:0]    ndig_q, ndig_d;
  logic [IDX_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [DIGIT_W-1:0]   dig_mem [INT_BITS];
  logic [DIGIT_W-1:0]   rd_data_q;
  logic                 dig_we;
  logic [PROD_W-1:0]    prod;
  logic [FRAC_BITS-1:0] frac_next;
  logic                 in_fire;
  logic                 div_start;
  logic [INT_BITS-1:0]  div_load;
  logic                 div_done;
  logic [INT_BITS-1:0]  div_quo;
  logic [DIGIT_W-1:0]   div_rem;
  logic                 chr_valid;
  logic                 chr_ready;
  rntd_char_t           chr;

  // Hold the radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // Saturate the radix and pick the fraction digit limit from floor(log2 radix)
  always_comb begin
    if (radix_q < RADIX_MIN) begin
      r_eff = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      r_eff = RADIX_MAX;
    end else begin
      r_eff = radix_q;
    end
    if (r_eff[5]) begin
      limit_eff = LIM_5;
    end else if (r_eff[4]) begin
      limit_eff = LIM_4;
    end else if (r_eff[3]) begin
      limit_eff = LIM_3;
    end else if (r_eff[2]) begin
      limit_eff = LIM_2;
    end else begin
      limit_eff = LIM_1;
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // One exact fraction step: digit is the carry out, the rest is the new fraction
  assign prod      = PROD_W'(frac_q) * PROD_W'(r_q);
  assign frac_next = prod[FRAC_BITS-1:0];

  // Integer digits come out of the divider least significant first
  rntd_div_unit #(
    .INT_BITS (INT_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_load),
    .divisor_i   (r_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Sequence division, read-back, point and fraction digits
  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    limit_d    = limit_q;
    frac_cnt_d = frac_cnt_q;
    frac_d     = frac_q;
    frac_nz_d  = frac_nz_q;
    ndig_d     = ndig_q;
    rd_ptr_d   = rd_ptr_q;
    div_start  = 1'b0;
    div_load   = div_quo;
    dig_we     = 1'b0;
    chr_valid  = 1'b0;
    chr.code   = digit_char(rd_data_q);
    chr.last   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          r_d        = r_eff;
          limit_d    = limit_eff;
          frac_cnt_d = '0;
          frac_d     = in_i.fraction_part;
          frac_nz_d  = |in_i.fraction_part;
          ndig_d     = '0;
          div_start  = 1'b1;
          div_load   = in_i.integer_part;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          dig_we = 1'b1;
          ndig_d = ndig_q + NDIG_W'(1);
          if (|div_quo) begin
            div_start = 1'b1;
          end else begin
            rd_ptr_d = ndig_q[IDX_W-1:0];
            state_d  = S_INT_RD;
          end
        end
      end
      S_INT_RD: begin
        state_d = S_INT_EMIT;
      end
      S_INT_EMIT: begin
        chr_valid = 1'b1;
        chr.last  = !frac_nz_q && (rd_ptr_q == '0);
        if (chr_ready) begin
          if (rd_ptr_q == '0) begin
            state_d = frac_nz_q ? S_POINT : S_IDLE;
          end else begin
            rd_ptr_d = rd_ptr_q - IDX_W'(1);
            state_d  = S_INT_RD;
          end
        end
      end
      S_POINT: begin
        chr_valid = 1'b1;
        chr.code  = CHAR_POINT;
        if (chr_ready) begin
          state_d = S_FRAC;
        end
      end
      S_FRAC: begin
        chr_valid = 1'b1;
        chr.code  = digit_char(prod[PROD_W-1:FRAC_BITS]);
        chr.last  = (frac_next == '0) || ((frac_cnt_q + CNT_W'(1)) == limit_q);
        if (chr_ready) begin
          frac_d     = frac_next;
          frac_cnt_d = frac_cnt_q + CNT_W'(1);
          if (chr.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      frac_cnt_q <= '0;
      frac_nz_q  <= 1'b0;
      ndig_q     <= '0;
      rd_ptr_q   <= '0;
    end else begin
      state_q    <= state_d;
      frac_cnt_q <= frac_cnt_d;
      frac_nz_q  <= frac_nz_d;
      ndig_q     <= ndig_d;
      rd_ptr_q   <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q     <= r_d;
    limit_q <= limit_d;
    frac_q  <= frac_d;
  end

  // Digit buffer: reverse the integer digits
  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      dig_mem[ndig_q[IDX_W-1:0]] <= div_rem;
    end
    rd_data_q <= dig_mem[rd_ptr_q];
  end

  rntd_pair_packer u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chr_valid_i (chr_valid),
    .chr_i       (chr),
    .chr_ready_o (chr_ready),
    .out_o       (out_o)
  );

  // The divider finishes only while the sequencer waits on it
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside division");

  // Read-back stays inside the digits already written
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INT_EMIT) |-> (NDIG_W'(rd_ptr_q) < ndig_q))
    else $error("digit read beyond written digits");

  // The fraction digit count never passes its limit
  a_frac_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FRAC) |-> (frac_cnt_q < limit_q))
    else $error("fraction digit count over limit");

  // A point is always followed by a fraction digit
  a_point_then_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POINT && chr_ready) |=> (state_q == S_FRAC))
    else $error("point not followed by fraction digits");

endmodule
